FILE: rtl/gn2d_pkg.sv
// gn2d_pkg: shared constants, types and the gradient table builder for the
// 2D gradient noise pipeline. No dependencies.
`timescale 1ns / 1ps

package gn2d_pkg;

   localparam int FRAC_BITS_DEF      = 16;
   localparam int COORD_INT_BITS_DEF = 16;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVAL  = 1'b1;

   localparam int HASH_X    = 713;
   localparam int HASH_Y    = 631;
   localparam int NOISE_MAX = 131071;
   localparam int NOISE_MIN = -131072;

   localparam longint PI_Q30 = 64'sd3373259426;

   typedef longint unsigned      u64_type;
   typedef logic signed [25:0]   grad_type;
   typedef grad_type             grad_rom_type [256];

   // shift-and-subtract quotient, only evaluated while building constant tables
   function automatic u64_type udiv_const(input u64_type n, input u64_type d);
      u64_type q;
      u64_type r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], n[i]};
         if (r >= d) begin
            r    = r - d;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // Q30 value clamped to [0, 1] and rounded to frac fraction bits
   function automatic longint q30_frac(input longint v, input int frac);
      longint r;
      r = v;
      if (r < 0) r = 0;
      if (r > (longint'(1) << 30)) r = longint'(1) << 30;
      return (r + (longint'(1) << (29 - frac))) >>> (30 - frac);
   endfunction

   // unit gradient table at angle 2*pi*k/255, evaluated at elaboration
   function automatic grad_rom_type grad_rom(input int frac, input bit want_sin);
      grad_rom_type rom;
      longint       t;
      longint       c;
      longint       s;
      u64_type      u;
      u64_type      x2;
      u64_type      term;
      bit           sneg;
      bit           cneg;
      for (int k = 0; k < 256; k++) begin
         t    = longint'(udiv_const(u64_type'(2 * PI_Q30 * longint'(k) + 127),
                                    u64_type'(255)));
         sneg = 1'b0;
         cneg = 1'b0;
         if (t > PI_Q30) begin
            t    = 2 * PI_Q30 - t;
            sneg = 1'b1;
         end
         if (t > (PI_Q30 >>> 1)) begin
            t    = PI_Q30 - t;
            cneg = 1'b1;
         end
         u    = u64_type'(t);
         x2   = (u * u + (u64_type'(1) << 29)) >> 30;
         c    = longint'(1) << 30;
         term = u64_type'(1) << 30;
         for (int n = 1; n <= 10; n++) begin
            term = udiv_const((term * x2) >> 30, u64_type'((2 * n - 1) * (2 * n)));
            c    = n[0] ? c - longint'(term) : c + longint'(term);
         end
         s    = longint'(u);
         term = u;
         for (int n = 1; n <= 10; n++) begin
            term = udiv_const((term * x2) >> 30, u64_type'((2 * n) * (2 * n + 1)));
            s    = n[0] ? s - longint'(term) : s + longint'(term);
         end
         c = q30_frac(c, frac);
         s = q30_frac(s, frac);
         rom[k] = want_sin ? grad_type'(sneg ? -s : s) : grad_type'(cneg ? -c : c);
      end
      return rom;
   endfunction

endpackage

FILE: rtl/gn2d_perm_mem.sv
// gn2d_perm_mem: 256 x 8 permutation table copy, one write port and two
// registered read ports. Depends on nothing.
`timescale 1ns / 1ps

module gn2d_perm_mem (
   input  logic       clock,
   input  logic       en,
   input  logic       wr_en,
   input  logic [7:0] wr_addr,
   input  logic [7:0] wr_data,
   input  logic [7:0] rd_addr_a,
   input  logic [7:0] rd_addr_b,
   output logic [7:0] rd_data_a_ff,
   output logic [7:0] rd_data_b_ff
);

   logic [7:0] mem [256];

   always_ff @(posedge clock) begin
      if (en && wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rd_data_a_ff <= mem[rd_addr_a];
         rd_data_b_ff <= mem[rd_addr_b];
      end
   end

endmodule

FILE: rtl/gn2d_lerp.sv
// gn2d_lerp: three-stage smoothstep blend a + round((b - a) * s).
// Uses gn2d_pkg for nothing but house consistency of widths.
`timescale 1ns / 1ps

module gn2d_lerp import gn2d_pkg::*; #(
   parameter int VW        = FRAC_BITS_DEF + 3,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic signed [VW-1:0]  a,
   input  logic signed [VW-1:0]  b,
   input  logic [FRAC_BITS:0]    s,
   output logic signed [VW:0]    res_ff
);

   localparam int PW = VW + FRAC_BITS + 3;

   logic signed [VW:0]          d_ff;
   logic signed [VW-1:0]        a1_ff;
   logic [FRAC_BITS:0]          s_ff;
   logic signed [PW-1:0]        prod_ff;
   logic signed [VW-1:0]        a2_ff;
   logic signed [PW-1:0]        rnd;
   logic signed [VW:0]          res_in;

   assign rnd    = (prod_ff + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
   assign res_in = $signed(rnd[VW:0]) + (VW + 1)'(a2_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff    <= (VW + 1)'(b) - (VW + 1)'(a);
         a1_ff   <= a;
         s_ff    <= s;
         prod_ff <= PW'(d_ff) * PW'($signed({1'b0, s_ff}));
         a2_ff   <= a1_ff;
         res_ff  <= res_in;
      end
   end

endmodule

FILE: rtl/gradient_noise_2d_core.sv
// gradient_noise_2d_core: top level of the 2D gradient noise pipeline.
// Depends on gn2d_pkg, gn2d_perm_mem and gn2d_lerp.
`timescale 1ns / 1ps

// One word per cycle in either operation while no result is stalled. An
// evaluate word gives its result after these registers in order: input,
// hash, table read, gradient lookup, multiply, dot round, three x-blend
// stages, three y-blend stages. A write word updates
// the permutation table when it reaches the table read stage and gives no
// result, so it orders correctly against evaluates on either side. A stalled
// result holds the whole pipeline; req_stall follows it.
module gradient_noise_2d_core import gn2d_pkg::*; #(
   parameter int FRAC_BITS      = FRAC_BITS_DEF,
   parameter int COORD_INT_BITS = COORD_INT_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_operation,
   input  logic [7:0]         req_table_index,
   input  logic [7:0]         req_table_value,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [17:0] rsp_noise_value
);

   localparam int F  = FRAC_BITS;
   localparam int W  = (COORD_INT_BITS + F > 32) ? 32 : COORD_INT_BITS + F;
   localparam int GW = W - F;
   localparam int HW = GW + 13;
   localparam int CW = F + 2;
   localparam int PW = 2 * CW;
   localparam int DW = F + 3;
   localparam int SW = F + 1;
   localparam int VW = DW + 2;
   localparam int TW = (VW > 18) ? VW : 18;
   localparam int NS = 10;

   localparam grad_rom_type COS_ROM = grad_rom(F, 1'b0);
   localparam grad_rom_type SIN_ROM = grad_rom(F, 1'b1);
   localparam logic signed [CW-1:0] ONE = CW'(1) <<< F;

   function automatic logic [7:0] hash_addr(input logic signed [HW-1:0] h);
      return h[HW-1] ? 8'(~h[7:0] + 8'd1) : h[7:0];
   endfunction

   function automatic logic [SW-1:0] sq_round(input logic [F-1:0] t);
      logic [2*F:0] p;
      p = (2 * F + 1)'(t * t) + ((2 * F + 1)'(1) << (F - 1));
      return p[F +: SW];
   endfunction

   function automatic logic [SW-1:0] smooth(input logic [F-1:0] t,
                                            input logic [SW-1:0] tt);
      logic [F+1:0]   m;
      logic [2*F+3:0] p;
      m = ((F + 2)'(3) << F) - (F + 2)'({t, 1'b0});
      p = (2 * F + 4)'(m) * (2 * F + 4)'(tt) + ((2 * F + 4)'(1) << (F - 1));
      return p[F +: SW];
   endfunction

   function automatic logic signed [DW-1:0] dot_round(input logic signed [PW-1:0] pc,
                                                      input logic signed [PW-1:0] ps);
      logic signed [PW:0] sum;
      sum = (PW + 1)'(pc) + (PW + 1)'(ps) + ((PW + 1)'(1) <<< (F - 1));
      sum = sum >>> F;
      return sum[DW-1:0];
   endfunction

   logic adv;

   // input register
   logic                p0_valid_ff;
   logic                p0_op_ff;
   logic [7:0]          p0_idx_ff;
   logic [7:0]          p0_val_ff;
   logic signed [W-1:0] p0_x_ff;
   logic signed [W-1:0] p0_y_ff;

   // hash stage
   logic signed [GW-1:0] gx;
   logic signed [GW-1:0] gy;
   logic signed [HW-1:0] cx0;
   logic signed [HW-1:0] cx1;
   logic signed [HW-1:0] cy0;
   logic signed [HW-1:0] cy1;
   logic signed [HW-1:0] hx0;
   logic signed [HW-1:0] hx1;
   logic signed [HW-1:0] hy0;
   logic signed [HW-1:0] hy1;

   logic         p1_valid_ff;
   logic         p1_op_ff;
   logic [7:0]   p1_idx_ff;
   logic [7:0]   p1_val_ff;
   logic [7:0]   p1_addr_ff [4];
   logic [F-1:0] p1_fx_ff;
   logic [F-1:0] p1_fy_ff;

   // table read stage
   logic [7:0]    k [4];
   logic          wr_en;
   logic [F-1:0]  p2_fx_ff;
   logic [F-1:0]  p2_fy_ff;
   logic [SW-1:0] p2_ttx_ff;
   logic [SW-1:0] p2_tty_ff;

   // gradient stage
   logic signed [CW-1:0] p3_cos_ff [4];
   logic signed [CW-1:0] p3_sin_ff [4];
   logic [F-1:0]         p3_fx_ff;
   logic [F-1:0]         p3_fy_ff;
   logic [SW-1:0]        p3_sx_ff;
   logic [SW-1:0]        p3_sy_ff;

   // multiply stage
   logic signed [CW-1:0] dx0;
   logic signed [CW-1:0] dx1;
   logic signed [CW-1:0] dy0;
   logic signed [CW-1:0] dy1;
   logic signed [PW-1:0] p4_pc_ff [4];
   logic signed [PW-1:0] p4_ps_ff [4];
   logic [SW-1:0]        p4_sx_ff;
   logic [SW-1:0]        p4_sy_ff;

   // dot stage
   logic signed [DW-1:0] p5_dot_ff [4];
   logic [SW-1:0]        p5_sx_ff;
   logic [SW-1:0]        p5_sy_ff;

   logic [SW-1:0]        sy_d_ff [3];
   logic signed [DW:0]   lo;
   logic signed [DW:0]   hi;
   logic signed [VW-1:0] v;
   logic signed [TW-1:0] vt;

   logic [NS-1:0] ev_ff;
   logic [NS-1:0] ev_in;

   assign adv       = ~(rsp_valid & rsp_stall);
   assign req_stall = ~adv;
   assign rsp_valid = ev_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff <= 1'b0;
         p1_valid_ff <= 1'b0;
         ev_ff       <= '0;
      end else if (adv) begin
         p0_valid_ff <= req_valid;
         p1_valid_ff <= p0_valid_ff;
         ev_ff       <= ev_in;
      end
   end

   assign ev_in = {ev_ff[NS-2:0], p1_valid_ff & (p1_op_ff == OP_EVAL)};

   always_ff @(posedge clock) begin
      if (adv) begin
         p0_op_ff  <= req_operation;
         p0_idx_ff <= req_table_index;
         p0_val_ff <= req_table_value;
         p0_x_ff   <= req_point_x[W-1:0];
         p0_y_ff   <= req_point_y[W-1:0];
      end
   end

   // corner hashes
   assign gx  = $signed(p0_x_ff[W-1:F]);
   assign gy  = $signed(p0_y_ff[W-1:F]);
   assign cx0 = HW'(gx);
   assign cx1 = HW'(gx) + HW'(1);
   assign cy0 = HW'(gy);
   assign cy1 = HW'(gy) + HW'(1);
   assign hx0 = cx0 * HW'(HASH_X);
   assign hx1 = cx1 * HW'(HASH_X);
   assign hy0 = cy0 * HW'(HASH_Y);
   assign hy1 = cy1 * HW'(HASH_Y);

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_op_ff      <= p0_op_ff;
         p1_idx_ff     <= p0_idx_ff;
         p1_val_ff     <= p0_val_ff;
         p1_addr_ff[0] <= hash_addr(hx0 + hy0);
         p1_addr_ff[1] <= hash_addr(hx1 + hy0);
         p1_addr_ff[2] <= hash_addr(hx0 + hy1);
         p1_addr_ff[3] <= hash_addr(hx1 + hy1);
         p1_fx_ff      <= p0_x_ff[F-1:0];
         p1_fy_ff      <= p0_y_ff[F-1:0];
      end
   end

   assign wr_en = p1_valid_ff & (p1_op_ff == OP_WRITE);

   gn2d_perm_mem u_mem_lo (
      .clock        (clock),
      .en           (adv),
      .wr_en        (wr_en),
      .wr_addr      (p1_idx_ff),
      .wr_data      (p1_val_ff),
      .rd_addr_a    (p1_addr_ff[0]),
      .rd_addr_b    (p1_addr_ff[1]),
      .rd_data_a_ff (k[0]),
      .rd_data_b_ff (k[1])
   );

   gn2d_perm_mem u_mem_hi (
      .clock        (clock),
      .en           (adv),
      .wr_en        (wr_en),
      .wr_addr      (p1_idx_ff),
      .wr_data      (p1_val_ff),
      .rd_addr_a    (p1_addr_ff[2]),
      .rd_addr_b    (p1_addr_ff[3]),
      .rd_data_a_ff (k[2]),
      .rd_data_b_ff (k[3])
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_fx_ff  <= p1_fx_ff;
         p2_fy_ff  <= p1_fy_ff;
         p2_ttx_ff <= sq_round(p1_fx_ff);
         p2_tty_ff <= sq_round(p1_fy_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 4; i++) begin
            p3_cos_ff[i] <= CW'(COS_ROM[k[i]]);
            p3_sin_ff[i] <= CW'(SIN_ROM[k[i]]);
         end
         p3_fx_ff <= p2_fx_ff;
         p3_fy_ff <= p2_fy_ff;
         p3_sx_ff <= smooth(p2_fx_ff, p2_ttx_ff);
         p3_sy_ff <= smooth(p2_fy_ff, p2_tty_ff);
      end
   end

   assign dx0 = $signed({2'b00, p3_fx_ff});
   assign dx1 = dx0 - ONE;
   assign dy0 = $signed({2'b00, p3_fy_ff});
   assign dy1 = dy0 - ONE;

   always_ff @(posedge clock) begin
      if (adv) begin
         p4_pc_ff[0] <= PW'(p3_cos_ff[0]) * PW'(dx0);
         p4_ps_ff[0] <= PW'(p3_sin_ff[0]) * PW'(dy0);
         p4_pc_ff[1] <= PW'(p3_cos_ff[1]) * PW'(dx1);
         p4_ps_ff[1] <= PW'(p3_sin_ff[1]) * PW'(dy0);
         p4_pc_ff[2] <= PW'(p3_cos_ff[2]) * PW'(dx0);
         p4_ps_ff[2] <= PW'(p3_sin_ff[2]) * PW'(dy1);
         p4_pc_ff[3] <= PW'(p3_cos_ff[3]) * PW'(dx1);
         p4_ps_ff[3] <= PW'(p3_sin_ff[3]) * PW'(dy1);
         p4_sx_ff    <= p3_sx_ff;
         p4_sy_ff    <= p3_sy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 4; i++) begin
            p5_dot_ff[i] <= dot_round(p4_pc_ff[i], p4_ps_ff[i]);
         end
         p5_sx_ff   <= p4_sx_ff;
         p5_sy_ff   <= p4_sy_ff;
         sy_d_ff[0] <= p5_sy_ff;
         sy_d_ff[1] <= sy_d_ff[0];
         sy_d_ff[2] <= sy_d_ff[1];
      end
   end

   gn2d_lerp #(.VW(DW), .FRAC_BITS(F)) u_lerp_lo (
      .clock  (clock),
      .en     (adv),
      .a      (p5_dot_ff[0]),
      .b      (p5_dot_ff[1]),
      .s      (p5_sx_ff),
      .res_ff (lo)
   );

   gn2d_lerp #(.VW(DW), .FRAC_BITS(F)) u_lerp_hi (
      .clock  (clock),
      .en     (adv),
      .a      (p5_dot_ff[2]),
      .b      (p5_dot_ff[3]),
      .s      (p5_sx_ff),
      .res_ff (hi)
   );

   gn2d_lerp #(.VW(DW + 1), .FRAC_BITS(F)) u_lerp_y (
      .clock  (clock),
      .en     (adv),
      .a      (lo),
      .b      (hi),
      .s      (sy_d_ff[2]),
      .res_ff (v)
   );

   // saturate to the 18-bit result range
   assign vt = TW'(v);
   always_comb begin
      if (vt > TW'(NOISE_MAX)) begin
         rsp_noise_value = 18'(NOISE_MAX);
      end else if (vt < TW'(NOISE_MIN)) begin
         rsp_noise_value = 18'(NOISE_MIN);
      end else begin
         rsp_noise_value = vt[17:0];
      end
   end

endmodule
